### design/rfsi_pkg.sv
// shared constants for the ring fifo with search and indexed access
// operation and status codes, register map, stream field positions
// no dependencies
package rfsi_pkg;

    localparam int DEF_MAX_SLOTS         = 16;
    localparam int DEF_MAX_ELEMENT_BYTES = 8;

    // stream field widths
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    // tdata layouts, lowest field first, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;
    localparam int S_FUNC_LSB   = 0;
    localparam int S_VALUE_LSB  = 3;
    localparam int S_OFFSET_LSB = 67;
    localparam int M_PAD_W      = 5;

    // configuration register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int SLOTS_W    = 5;
    localparam int EBYTES_W   = 4;
    localparam logic REG_SLOTS_IN_USE  = 1'b0;
    localparam logic REG_ELEMENT_BYTES = 1'b1;
    localparam logic [SLOTS_W-1:0]  SLOTS_RESET  = 5'd16;
    localparam logic [EBYTES_W-1:0] EBYTES_RESET = 4'd8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP       = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_OVERWRITE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

endpackage

### design/ring_fifo_with_search_and_index.sv
// ring fifo with search and indexed access: top level with sequencer and config port
// depends on rfsi_pkg and rfsi_mem
//
// usage:
//   s_* stream carries one operation per request (push, pop, search, read at
//   offset, overwrite at offset, clear); m_* stream returns one result per
//   request with status, data, count and free slots after the operation.
//   the apb port sets slots_in_use (address 0, also empties the queue) and
//   element_bytes (address 4); write it only while no request is in flight.
// timing:
//   one request at a time; s_tready is high only while the sequencer is idle.
//   push, overwrite, clear and errors pass through the exec and done states back to idle,
//   pop and read at offset add the rd state between them (one registered store read).
//   search: compares k entries (up to the count) in the srch state, since one
//   shared comparator checks one stored entry per cycle from oldest on.
//   the result is registered onto m_tvalid from the done state, which waits while an earlier result stalls.
// reset: both ring pointers go to zero, config returns to 16 slots of 8 bytes;
//   the store itself is not cleared and only entries inside the count are read.
// stall: a result waits in the output register while m_tready is low; the next
//   request can be taken meanwhile but its result holds until the first leaves.
module ring_fifo_with_search_and_index #(
    parameter int MAX_SLOTS         = rfsi_pkg::DEF_MAX_SLOTS,
    parameter int MAX_ELEMENT_BYTES = rfsi_pkg::DEF_MAX_ELEMENT_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfsi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rfsi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rfsi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rfsi_pkg::S_TDATA_W-1:0]  s_tdata,  // func[2:0], value[66:3], offset[70:67]
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rfsi_pkg::M_TDATA_W-1:0]  m_tdata   // status[2:0], data[66:3], count[70:67],
                                                      // free_slots[74:71]
);

    localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int EW = 8 * MAX_ELEMENT_BYTES;
    localparam int SW = ((NW > rfsi_pkg::OFFSET_W) ? NW : rfsi_pkg::OFFSET_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_SRCH,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [rfsi_pkg::SLOTS_W-1:0]    slots_reg, slots_next;
    logic [rfsi_pkg::EBYTES_W-1:0]   ebytes_reg, ebytes_next;
    logic [PW-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic                            m_valid_reg, m_valid_next;

    logic [rfsi_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [EW-1:0]                   val_reg, val_next;
    logic [rfsi_pkg::OFFSET_W-1:0]   off_reg, off_next;
    logic [PW-1:0]                   scan_reg, scan_next;
    logic [NW-1:0]                   left_reg, left_next;
    logic [rfsi_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [EW-1:0]                   res_data_reg, res_data_next;
    logic [rfsi_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [EW-1:0]                   out_data_reg, out_data_next;
    logic [rfsi_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;
    logic [rfsi_pkg::COUNT_W-1:0]    out_free_reg, out_free_next;

    logic [NW-1:0]                   ring_n;
    logic [rfsi_pkg::EBYTES_W-1:0]   ebytes_eff;
    logic [EW-1:0]                   elem_mask;
    logic [NW-1:0]                   cnt_now;
    logic [SW-1:0]                   idx_sum;
    logic [PW-1:0]                   idx_slot;
    logic                            off_bad;
    logic                            hit;
    logic                            cfg_wr;
    logic                            cfg_idx;

    logic                            mem_wr_en;
    logic [PW-1:0]                   mem_waddr;
    logic                            mem_rd_en;
    logic [PW-1:0]                   mem_raddr;
    logic [EW-1:0]                   mem_rdata;

    function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p, input logic [NW-1:0] n);
        logic [PW-1:0] r;
        if (NW'(p) + NW'(1) == n)
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    rfsi_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .wr_en (mem_wr_en),
        .waddr (mem_waddr),
        .wdata (val_reg),
        .rd_en (mem_rd_en),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;

    always_comb
    begin
        case (cfg_idx)
            rfsi_pkg::REG_SLOTS_IN_USE:  prdata = rfsi_pkg::APB_DATA_W'(slots_reg);
            rfsi_pkg::REG_ELEMENT_BYTES: prdata = rfsi_pkg::APB_DATA_W'(ebytes_reg);
            default:                     prdata = '0;
        endcase
    end

    // effective ring size and element mask
    always_comb
    begin
        if (slots_reg < rfsi_pkg::SLOTS_W'(2))
        begin
            ring_n = NW'(2);
        end
        else if (32'(slots_reg) > 32'(MAX_SLOTS))
        begin
            ring_n = NW'(MAX_SLOTS);
        end
        else
        begin
            ring_n = NW'(slots_reg);
        end

        if (ebytes_reg == '0)
        begin
            ebytes_eff = rfsi_pkg::EBYTES_W'(1);
        end
        else if (32'(ebytes_reg) > 32'(MAX_ELEMENT_BYTES))
        begin
            ebytes_eff = rfsi_pkg::EBYTES_W'(MAX_ELEMENT_BYTES);
        end
        else
        begin
            ebytes_eff = ebytes_reg;
        end

        for (int i = 0; i < MAX_ELEMENT_BYTES; i++)
        begin
            elem_mask[8*i +: 8] = (ebytes_eff > rfsi_pkg::EBYTES_W'(i)) ? 8'hFF : 8'h00;
        end
    end

    // occupancy, indexed slot and the shared compare
    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            cnt_now = NW'(wr_ptr_reg - rd_ptr_reg);
        end
        else
        begin
            cnt_now = ring_n - NW'(rd_ptr_reg - wr_ptr_reg);
        end

        idx_sum = SW'(rd_ptr_reg) + SW'(off_reg);
        if (idx_sum >= SW'(ring_n))
        begin
            idx_sum = idx_sum - SW'(ring_n);
        end
        idx_slot = PW'(idx_sum);
        off_bad  = SW'(off_reg) >= SW'(cnt_now);
        hit      = (mem_rdata & elem_mask) == val_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        slots_next      = slots_reg;
        ebytes_next     = ebytes_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        func_next       = func_reg;
        val_next        = val_reg;
        off_next        = off_reg;
        scan_next       = scan_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_free_next   = out_free_reg;
        mem_wr_en       = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_rd_en       = 1'b0;
        mem_raddr       = rd_ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tdata[rfsi_pkg::S_FUNC_LSB +: rfsi_pkg::FUNC_W];
                    val_next   = s_tdata[rfsi_pkg::S_VALUE_LSB +: EW] & elem_mask;
                    off_next   = s_tdata[rfsi_pkg::S_OFFSET_LSB +: rfsi_pkg::OFFSET_W];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = rfsi_pkg::ST_OK;
                res_data_next   = '0;
                state_next      = S_DONE;
                case (func_reg)
                    rfsi_pkg::FUNC_PUSH:
                    begin
                        if (cnt_now == ring_n - NW'(1))
                        begin
                            res_status_next = rfsi_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_waddr   = wr_ptr_reg;
                            wr_ptr_next = step_ptr(wr_ptr_reg, ring_n);
                        end
                    end
                    rfsi_pkg::FUNC_POP:
                    begin
                        if (cnt_now == '0)
                        begin
                            res_status_next = rfsi_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_raddr   = rd_ptr_reg;
                            rd_ptr_next = step_ptr(rd_ptr_reg, ring_n);
                            state_next  = S_RD;
                        end
                    end
                    rfsi_pkg::FUNC_SEARCH:
                    begin
                        if (cnt_now == '0)
                        begin
                            res_status_next = rfsi_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            mem_raddr  = rd_ptr_reg;
                            scan_next  = step_ptr(rd_ptr_reg, ring_n);
                            left_next  = cnt_now - NW'(1);
                            state_next = S_SRCH;
                        end
                    end
                    rfsi_pkg::FUNC_READ:
                    begin
                        if (off_bad)
                        begin
                            res_status_next = rfsi_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            mem_raddr  = idx_slot;
                            state_next = S_RD;
                        end
                    end
                    rfsi_pkg::FUNC_OVERWRITE:
                    begin
                        if (off_bad)
                        begin
                            res_status_next = rfsi_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_wr_en = 1'b1;
                            mem_waddr = idx_slot;
                        end
                    end
                    rfsi_pkg::FUNC_CLEAR:
                    begin
                        rd_ptr_next = '0;
                        wr_ptr_next = '0;
                    end
                    default:
                    begin
                        res_status_next = rfsi_pkg::ST_OK;
                    end
                endcase
            end

            S_RD:
            begin
                res_data_next = mem_rdata & elem_mask;
                state_next    = S_DONE;
            end

            // one stored entry compared per cycle while the next one is fetched
            S_SRCH:
            begin
                if (hit)
                begin
                    res_status_next = rfsi_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else if (left_reg == '0)
                begin
                    res_status_next = rfsi_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_rd_en = 1'b1;
                    mem_raddr = scan_reg;
                    scan_next = step_ptr(scan_reg, ring_n);
                    left_next = left_reg - NW'(1);
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = rfsi_pkg::COUNT_W'(cnt_now);
                    out_free_next   = rfsi_pkg::COUNT_W'(ring_n - NW'(1) - cnt_now);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a slot count write empties the ring
        if (cfg_wr)
        begin
            case (cfg_idx)
                rfsi_pkg::REG_SLOTS_IN_USE:
                begin
                    slots_next  = pwdata[rfsi_pkg::SLOTS_W-1:0];
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                end
                rfsi_pkg::REG_ELEMENT_BYTES:
                begin
                    ebytes_next = pwdata[rfsi_pkg::EBYTES_W-1:0];
                end
                default:
                begin
                    slots_next = slots_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slots_reg   <= rfsi_pkg::SLOTS_RESET;
            ebytes_reg  <= rfsi_pkg::EBYTES_RESET;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slots_reg   <= slots_next;
            ebytes_reg  <= ebytes_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        val_reg        <= val_next;
        off_reg        <= off_next;
        scan_reg       <= scan_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_free_reg   <= out_free_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{rfsi_pkg::M_PAD_W{1'b0}}, out_free_reg, out_count_reg,
                       rfsi_pkg::VALUE_W'(out_data_reg), out_status_reg};

endmodule

### design/rfsi_mem.sv
// element store of the ring: one write port, one read port, registered read data
// no package dependencies
module rfsi_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/rfsi_chk.sv
// port-level checker for the ring fifo with search, bound to the top level
// depends on rfsi_pkg
module rfsi_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rfsi_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [rfsi_pkg::STATUS_W-1:0] st;
    logic [rfsi_pkg::VALUE_W-1:0]  dat;
    logic [rfsi_pkg::COUNT_W-1:0]  cnt;
    logic [rfsi_pkg::COUNT_W-1:0]  fre;

    assign st  = m_tdata[2:0];
    assign dat = m_tdata[66:3];
    assign cnt = m_tdata[70:67];
    assign fre = m_tdata[74:71];

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still in work");

    // data only carries a popped or read element
    a_data_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st != rfsi_pkg::ST_OK |-> dat == '0)
        else $error("nonzero data with error status");

    a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == rfsi_pkg::ST_FULL |-> fre == '0)
        else $error("dropped push while free slots reported");

    a_empty_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == rfsi_pkg::ST_EMPTY |-> cnt == '0)
        else $error("empty pop while entries reported");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind ring_fifo_with_search_and_index rfsi_chk u_rfsi_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb_ring_fifo_with_search_and_index.sv
// testbench for ring_fifo_with_search_and_index: directed and random requests on the
// stream port, register changes over apb, results checked against a shadow of the ring
// depends on rfsi_pkg and the design files
module tb_ring_fifo_with_search_and_index;

    import rfsi_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
    localparam int QUIET_LIMIT    = 1000;
    localparam int PHASE_REQUESTS = 183;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  free_slots;
    } result_t;

    // shadow copy of the ring: predicts each result and holds those still due
    class ring_shadow;
        logic [VALUE_W-1:0]  slot_copy [DEF_MAX_SLOTS];
        int unsigned         oldest;
        int unsigned         next_free;
        logic [SLOTS_W-1:0]  slots_setting;
        logic [EBYTES_W-1:0] bytes_setting;
        result_t             awaited_results [$];
        int unsigned         error_count;

        function new();
            foreach (slot_copy[i])
                slot_copy[i] = '0;
            oldest        = 0;
            next_free     = 0;
            slots_setting = SLOTS_RESET;
            bytes_setting = EBYTES_RESET;
            error_count   = 0;
        endfunction

        function int unsigned ring_size();
            if (slots_setting < 2)
                return 2;
            if (slots_setting > DEF_MAX_SLOTS)
                return DEF_MAX_SLOTS;
            return slots_setting;
        endfunction

        function logic [VALUE_W-1:0] element_mask();
            int unsigned b;
            b = bytes_setting;
            if (b < 1)
                b = 1;
            if (b >= DEF_MAX_ELEMENT_BYTES)
                return '1;
            return (64'd1 << (8 * b)) - 64'd1;
        endfunction

        function int unsigned held_entries();
            int unsigned n;
            n = ring_size();
            return (next_free + n - oldest) % n;
        endfunction

        function logic [VALUE_W-1:0] entry_at(int unsigned pos);
            return slot_copy[(oldest + pos) % ring_size()] & element_mask();
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void write_setting(logic idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_SLOTS_IN_USE)
            begin
                slots_setting = value[SLOTS_W-1:0];
                oldest        = 0;
                next_free     = 0;
            end
            else
                bytes_setting = value[EBYTES_W-1:0];
        endfunction

        function void apply_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                                    logic [OFFSET_W-1:0] offset);
            int unsigned        n;
            int unsigned        held;
            int unsigned        k;
            logic [VALUE_W-1:0] mask;
            logic [VALUE_W-1:0] elem;
            result_t            r;
            n    = ring_size();
            mask = element_mask();
            elem = value & mask;
            oldest    = oldest % n;
            next_free = next_free % n;
            held = held_entries();
            r.status = ST_OK;
            r.data   = '0;
            case (func)
                FUNC_PUSH:
                    if (held >= n - 1)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_copy[next_free] = elem;
                        next_free = (next_free + 1) % n;
                    end
                FUNC_POP:
                    if (held == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.data = slot_copy[oldest] & mask;
                        oldest = (oldest + 1) % n;
                    end
                FUNC_SEARCH:
                begin
                    r.status = ST_NOT_FOUND;
                    for (k = 0; k < held; k++)
                        if (((slot_copy[(oldest + k) % n] ^ elem) & mask) == '0)
                            r.status = ST_OK;
                end
                FUNC_READ:
                    if (offset >= held)
                        r.status = ST_RANGE;
                    else
                        r.data = slot_copy[(oldest + offset) % n] & mask;
                FUNC_OVERWRITE:
                    if (offset >= held)
                        r.status = ST_RANGE;
                    else
                        slot_copy[(oldest + offset) % n] = elem;
                FUNC_CLEAR:
                begin
                    oldest    = 0;
                    next_free = 0;
                end
                default:
                    ;
            endcase
            held = held_entries();
            r.count      = 4'(held);
            r.free_slots = 4'(n - 1 - held);
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            result_t got;
            result_t want;
            got.status     = beat[0 +: STATUS_W];
            got.data       = beat[STATUS_W +: VALUE_W];
            got.count      = beat[STATUS_W + VALUE_W +: COUNT_W];
            got.free_slots = beat[STATUS_W + VALUE_W + COUNT_W +: COUNT_W];
            if (awaited_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result %0h with no request outstanding", $time, beat);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("data", want.data, got.data);
            compare_field("count", want.count, got.count);
            compare_field("free_slots", want.free_slots, got.free_slots);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // func[2:0], value[66:3], offset[70:67], pad[71]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // status[2:0], data[66:3], count[70:67],
                                      // free_slots[74:71], pad[79:75]

    ring_shadow shadow = new();
    bit         send_steady;

    ring_fifo_with_search_and_index u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [VALUE_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // returns psel and penable to idle after the access so that writes can follow each other
    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.write_setting(idx, value);
        @(posedge clk);
    endtask

    // leaves tvalid high on return; the caller lowers it or sends again in the same step
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                                input logic [OFFSET_W-1:0] offset);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, offset, value, func};
        do @(posedge clk); while (!s_tready);
        shadow.apply_request(func, value, offset);
    endtask

    // stop sending, wait on the clock and then until every result has drained
    task automatic hold_requests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_request(input bit filling);
        int unsigned         pick;
        int unsigned         held;
        logic [FUNC_W-1:0]   func;
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  mask;
        logic [OFFSET_W-1:0] offset;
        held = shadow.held_entries();
        mask = shadow.element_mask();
        pick = $urandom_range(0, 99);
        if (pick < (filling ? 45 : 15))
            func = FUNC_PUSH;
        else if (pick < 60)
            func = FUNC_POP;
        else if (pick < 73)
            func = FUNC_SEARCH;
        else if (pick < 85)
            func = FUNC_READ;
        else if (pick < 95)
            func = FUNC_OVERWRITE;
        else if (pick < 97)
            func = FUNC_CLEAR;
        else
            func = ($urandom_range(0, 1) == 0) ? FUNC_SPARE6 : FUNC_SPARE7;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            value = '1;
        else if (pick == 1)
            value = '0;
        else
            value = random_word();
        // mostly search for something held, with junk above the element bytes
        if (func == FUNC_SEARCH && held != 0 && $urandom_range(0, 9) < 7)
            value = shadow.entry_at($urandom_range(0, held - 1)) | (random_word() & ~mask);
        if (held != 0 && $urandom_range(0, 9) < 8)
            offset = 4'($urandom_range(0, held - 1));
        else
            offset = 4'($urandom_range(0, 15));
        send_request(func, value, offset);
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        bit          steady;
        steady = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            shadow.check_result(m_tdata);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned slot_choices [10];
        int unsigned byte_choices [10];
        bit          filling;
        slot_choices = '{2, 16, 7, 0, 31, 11, 1, 17, 4, 3};
        byte_choices = '{1, 8, 3, 0, 15, 2, 9, 8, 5, 4};
        filling  = 1'b0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue errors, then a few entries at reset settings
        send_request(FUNC_POP, '0, '0);
        send_request(FUNC_SEARCH, '1, '0);
        send_request(FUNC_READ, '0, '0);
        send_request(FUNC_OVERWRITE, '1, '0);
        send_request(FUNC_PUSH, '1, '0);
        send_request(FUNC_PUSH, '0, 4'd15);
        send_request(FUNC_PUSH, 64'hA5A5_5A5A_0123_4567, '0);
        send_request(FUNC_SEARCH, '0, '0);
        send_request(FUNC_SEARCH, 64'hA5A5_5A5A_0123_4567, '0);
        send_request(FUNC_SEARCH, 64'h0000_0000_0000_0123, '0);
        send_request(FUNC_READ, '0, 4'd2);
        send_request(FUNC_READ, '0, 4'd3);
        send_request(FUNC_OVERWRITE, 64'h5555_AAAA_5555_AAAA, 4'd1);
        send_request(FUNC_READ, '0, 4'd1);
        send_request(FUNC_SPARE6, '1, 4'd15);
        send_request(FUNC_SPARE7, '0, '0);
        send_request(FUNC_POP, '1, '0);
        send_request(FUNC_CLEAR, '0, '0);
        send_request(FUNC_POP, '0, '0);
        hold_requests();

        // smallest ring and one-byte elements: full after a single push
        apb_write(REG_SLOTS_IN_USE, 32'd2);
        apb_write(REG_ELEMENT_BYTES, 32'd1);
        send_request(FUNC_PUSH, 64'hFFFF_FFFF_FFFF_FF81, '0);
        send_request(FUNC_PUSH, 64'h0000_0000_0000_0042, '0);
        send_request(FUNC_SEARCH, 64'h0000_0000_0000_1281, '0);
        send_request(FUNC_READ, '1, 4'd15);
        send_request(FUNC_POP, '0, '0);

        for (int ph = 0; ph < 10; ph++)
        begin
            hold_requests();
            // every third phase keeps the entries and only changes the element size
            if (ph % 3 != 2)
                apb_write(REG_SLOTS_IN_USE, slot_choices[ph]);
            apb_write(REG_ELEMENT_BYTES, byte_choices[ph]);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                if (i % 50 == 0)
                    filling = !filling;
                if ($urandom_range(0, 149) == 0)
                    hold_requests();
                send_random_request(filling);
            end
        end

        hold_requests();
        repeat (20) @(posedge clk);
        if (shadow.error_count == 0 && shadow.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
design/rfsi_pkg.sv
design/rfsi_mem.sv
design/ring_fifo_with_search_and_index.sv
design/rfsi_chk.sv
test/tb_ring_fifo_with_search_and_index.sv
